### rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// shared types and codes for the sorted linked list insert block
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int KEY_W  = 32;
  localparam int NODE_W = 7;
  localparam int PREV_W = 8;

  typedef logic [0:0] status_t;

  localparam status_t STATUS_OK   = 1'b0;
  localparam status_t STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_LINK,
    S_PREV,
    S_RESULT
  } sll_state_t;

endpackage

### rtl/sorted_linked_list_insert.sv
// ----------------------------------------------------------------------------
// sorted_linked_list_insert
// sorted singly linked list of signed keys kept in a node store with a free list
// ----------------------------------------------------------------------------
// Each request carries one signed Q16.16 key. The block takes the node at the
// head of the free list, stores the key there, walks the sorted list from its
// head to the first node whose key is not less than the new key and links the
// new node in front of it, so a new key lands ahead of equal keys already in
// the list. One result comes back per request: status 0 with the node slot and
// its predecessor (NODE_COUNT when the node became the list head), or status 1
// with zero fields when no node is free, in which case nothing changes. Keys and
// links live in two memories with registered read data; the walk reads one
// list node per cycle by feeding the link just read straight back as the next
// read address. A request goes through S_ALLOC, S_WALK for a non-empty list,
// S_LINK, S_PREV when the new node has a predecessor and S_RESULT, in that
// order; a full store goes straight to S_RESULT. One request is in flight at
// a time, but a new request is taken while the previous result still waits
// on out_stall.
// Unwritten link entries read as their reset value through a fill count, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_linked_list_insert #(
  parameter int NODE_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [sll_pkg::KEY_W-1:0] in_new_key,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output sll_pkg::status_t              out_status,
  output logic [sll_pkg::NODE_W-1:0]    out_node_index,
  output logic [sll_pkg::PREV_W-1:0]    out_prev_index
);

  import sll_pkg::*;

  // node address width and link width (a link also holds the nil code)
  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LINK_W = $clog2(NODE_COUNT + 1);
  localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(NODE_COUNT);
  localparam logic [LINK_W-1:0] STEP_LAST = LINK_W'(NODE_COUNT - 1);

  sll_state_t state_r, state_nxt;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [LINK_W-1:0] node_r, node_nxt;
  logic [LINK_W-1:0] prev_r, prev_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  logic [LINK_W-1:0] list_head_r, list_head_nxt;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] fill_r, fill_nxt;
  logic              full_r, full_nxt;

  // read tracking: which entry was read and whether its link was ever written
  logic [ADDR_W-1:0] rd_idx_r;
  logic              rd_fresh_r;

  // result register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic [PREV_W-1:0] out_prev_r, out_prev_nxt;

  // memory ports
  logic              key_we;
  logic [ADDR_W-1:0] key_waddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              link_we;
  logic [ADDR_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [LINK_W-1:0] link_rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [LINK_W-1:0] link_val;
  logic              link_is_node;
  logic              key_below;
  logic [15:0]       node_wide;

  sll_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NODE_COUNT)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rdata)
  );

  sll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODE_COUNT)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_rdata)
  );

  // link entries at or above the fill count still hold their reset value i+1
  assign link_val     = rd_fresh_r ? link_rdata : (LINK_W'(rd_idx_r) + LINK_W'(1));
  assign link_is_node = (link_val < LINK_NIL);
  assign key_below    = ($signed(key_rdata) < key_r);
  assign node_wide    = 16'(node_r);

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_r;
  assign out_prev_index = out_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= LINK_NIL;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    node_r       <= node_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    full_r       <= full_nxt;
    out_status_r <= out_status_nxt;
    out_node_r   <= out_node_nxt;
    out_prev_r   <= out_prev_nxt;
    if (rd_en) begin
      rd_idx_r   <= rd_addr;
      rd_fresh_r <= (LINK_W'(rd_addr) < fill_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    node_nxt       = node_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_node_nxt   = out_node_r;
    out_prev_nxt   = out_prev_r;
    key_we         = 1'b0;
    key_waddr      = free_head_r[ADDR_W-1:0];
    link_we        = 1'b0;
    link_waddr     = node_r[ADDR_W-1:0];
    link_wdata     = cur_r;
    rd_en          = 1'b0;
    rd_addr        = free_head_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (free_head_r == LINK_NIL) begin
            // no free node: report full, leave everything alone
            full_nxt  = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            // latch the key and fetch the next free link
            full_nxt  = 1'b0;
            key_nxt   = in_new_key;
            node_nxt  = free_head_r;
            rd_en     = 1'b1;
            state_nxt = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        // latched key goes into the new node
        key_we        = 1'b1;
        key_waddr     = node_r[ADDR_W-1:0];
        free_head_nxt = link_is_node ? link_val : LINK_NIL;
        prev_nxt      = LINK_NIL;
        cur_nxt       = list_head_r;
        steps_nxt     = '0;
        if (list_head_r < LINK_NIL) begin
          rd_en     = 1'b1;
          rd_addr   = list_head_r[ADDR_W-1:0];
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_LINK;
        end
      end

      S_WALK: begin
        // key and link of cur_r are on the memory outputs
        if (!key_below) begin
          state_nxt = S_LINK;
        end else begin
          prev_nxt  = cur_r;
          steps_nxt = steps_r + LINK_W'(1);
          if (link_is_node && (steps_r < STEP_LAST)) begin
            // next node's address comes straight from the link just read
            cur_nxt = link_val;
            rd_en   = 1'b1;
            rd_addr = link_val[ADDR_W-1:0];
          end else begin
            cur_nxt   = link_is_node ? link_val : LINK_NIL;
            state_nxt = S_LINK;
          end
        end
      end

      S_LINK: begin
        // new node points at the first node not below it
        link_we    = 1'b1;
        link_waddr = node_r[ADDR_W-1:0];
        link_wdata = cur_r;
        fill_nxt   = fill_r + LINK_W'(1);
        if (prev_r == LINK_NIL) begin
          list_head_nxt = node_r;
          state_nxt     = S_RESULT;
        end else begin
          state_nxt = S_PREV;
        end
      end

      S_PREV: begin
        link_we    = 1'b1;
        link_waddr = prev_r[ADDR_W-1:0];
        link_wdata = node_r;
        state_nxt  = S_RESULT;
      end

      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = full_r ? STATUS_FULL : STATUS_OK;
          out_node_nxt   = full_r ? '0 : node_wide[NODE_W-1:0];
          out_prev_nxt   = full_r ? '0 : PREV_W'(prev_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // free list is consumed in slot order, so its head tracks the fill count
  a_free_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (free_head_r == fill_r))
    else $error("free list head out of step with fill count");

  // a full report only when no node is left
  a_full_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_FULL)) |-> (free_head_r == LINK_NIL))
    else $error("full reported while a node is free");

  // the walk never passes more nodes than the store holds
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r < LINK_NIL))
    else $error("list walk ran past the store size");

  // the list head is never a free node
  a_head_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r != LINK_NIL) |-> (list_head_r < fill_r))
    else $error("list head points at an unallocated node");

endmodule

### rtl/sll_ram.sv
// ----------------------------------------------------------------------------
// sll_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
